### rtl/core/kmpd_pkg.sv
// Shared types and constants of the keypad matrix press detector.
// Used by every module under rtl/core; depends on nothing.

package kmpd_pkg;

	localparam int MAX_COLUMNS = 8;
	localparam int MAX_ROWS    = 8;

	// Columns actually scanned: bounded by the build limit and the sample width.
	localparam int SCAN_COLS = (MAX_COLUMNS < 8) ? MAX_COLUMNS : 8;
	localparam int ROWS_USED = (MAX_ROWS < 8) ? MAX_ROWS : 8;
	localparam int ROW_W     = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
	localparam int COL_W     = (SCAN_COLS > 1) ? $clog2(SCAN_COLS) : 1;

	// Two event slots per column: release/press-start first, long press second.
	localparam int SLOTS  = 2 * SCAN_COLS;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] LONG_PRESS_RESET = 8'd50;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t REG_SCAN_ENABLE      = 2'd0;
	localparam cfg_index_t REG_COLUMN_COUNT     = 2'd1;
	localparam cfg_index_t REG_ROW_COUNT        = 2'd2;
	localparam cfg_index_t REG_LONG_PRESS_TICKS = 2'd3;

	typedef enum logic [1:0] {
		EV_START = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [2:0] row_index;
		logic [7:0] column_pressed;
	} sample_t;

	typedef struct packed {
		event_kind_t event_kind;
		logic [5:0]  key_number;
		logic        last_event;
	} result_t;

	// Work left for one row sample: pending event slots and what they need.
	typedef struct packed {
		logic [SLOTS-1:0]     slot_mask;
		logic [SCAN_COLS-1:0] pressed;
		logic [5:0]           key_base;
	} desc_t;

	typedef struct packed {
		logic  push;
		desc_t data;
	} qwr_t;

endpackage

### rtl/core/kmpd_front.sv
// Front end: configuration registers, per-key hold counters and event classification.
// Depends on kmpd_pkg.

module kmpd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  kmpd_pkg::cfg_index_t cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 push,
	output logic                 full,
	input  kmpd_pkg::sample_t    sample,
	input  logic                 q_full,
	output kmpd_pkg::qwr_t       q_wr
);

	logic       scan_enable_q;
	logic [3:0] column_count_q;
	logic [3:0] row_count_q;
	logic [7:0] long_press_ticks_q;

	// One word per row, holding the counters of all its columns.
	logic [kmpd_pkg::SCAN_COLS-1:0][7:0] cnt_q [kmpd_pkg::ROWS_USED];

	logic [kmpd_pkg::ROW_W-1:0]          row_sel;
	logic                                row_ok;
	logic                                hit;
	logic [7:0]                          thr;
	logic [7:0]                          thr_m1;
	logic [7:0]                          cnt_cur [kmpd_pkg::SCAN_COLS];
	logic [7:0]                          cnt_inc [kmpd_pkg::SCAN_COLS];
	logic [kmpd_pkg::SCAN_COLS-1:0][7:0] cnt_nxt;
	logic [kmpd_pkg::SCAN_COLS-1:0]      ev_first;
	logic [kmpd_pkg::SCAN_COLS-1:0]      ev_long;
	logic [kmpd_pkg::SCAN_COLS-1:0]      pressed;
	logic [kmpd_pkg::SLOTS-1:0]          mask;
	logic [5:0]                          base_prod;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q      <= 1'b0;
			column_count_q     <= 4'd0;
			row_count_q        <= 4'd0;
			long_press_ticks_q <= kmpd_pkg::LONG_PRESS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				kmpd_pkg::REG_SCAN_ENABLE:      scan_enable_q      <= cfg_data[0];
				kmpd_pkg::REG_COLUMN_COUNT:     column_count_q     <= cfg_data[3:0];
				kmpd_pkg::REG_ROW_COUNT:        row_count_q        <= cfg_data[3:0];
				kmpd_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign row_sel = sample.row_index[kmpd_pkg::ROW_W-1:0];
	assign row_ok  = ({1'b0, sample.row_index} < row_count_q) &&
		({1'b0, sample.row_index} < 4'(kmpd_pkg::ROWS_USED));
	assign hit     = push && !q_full && scan_enable_q && row_ok;

	// A threshold of zero behaves as one.
	assign thr    = (long_press_ticks_q == 8'd0) ? 8'd1 : long_press_ticks_q;
	assign thr_m1 = thr - 8'd1;

	always_comb begin
		for (int x = 0; x < kmpd_pkg::SCAN_COLS; x++) begin
			cnt_cur[x] = cnt_q[row_sel][x];
			pressed[x] = sample.column_pressed[x];
			cnt_inc[x] = (cnt_cur[x] < thr_m1) ? cnt_cur[x] + 8'd1 : cnt_cur[x];
			if (column_count_q <= 4'(x)) begin
				ev_first[x] = 1'b0;
				ev_long[x]  = 1'b0;
				cnt_nxt[x]  = cnt_cur[x];
			end else if (!pressed[x]) begin
				ev_first[x] = (cnt_cur[x] != 8'd0) && (cnt_cur[x] < thr);
				ev_long[x]  = 1'b0;
				cnt_nxt[x]  = 8'd0;
			end else begin
				ev_first[x] = (cnt_cur[x] == 8'd0);
				ev_long[x]  = (cnt_inc[x] == thr_m1);
				cnt_nxt[x]  = ev_long[x] ? cnt_inc[x] + 8'd1 : cnt_inc[x];
			end
			mask[2*x]   = ev_first[x];
			mask[2*x+1] = ev_long[x];
		end
	end

	// Only the low six bits of the key number are kept.
	assign base_prod = 6'(sample.row_index) * 6'(column_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < kmpd_pkg::ROWS_USED; r++) begin
				cnt_q[r] <= '0;
			end
		end else if (hit) begin
			cnt_q[row_sel] <= cnt_nxt;
		end
	end

	// Samples that cause no event leave nothing for the back end.
	assign q_wr.push           = hit && (|mask);
	assign q_wr.data.slot_mask = mask;
	assign q_wr.data.pressed   = pressed;
	assign q_wr.data.key_base  = base_prod;

endmodule

### rtl/core/kmpd_queue.sv
// Short descriptor queue between the front end and the event serializer.
// Depends on kmpd_pkg.

module kmpd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  kmpd_pkg::qwr_t  wr,
	output logic            q_full,
	input  logic            rd_pop,
	output logic            q_empty,
	output kmpd_pkg::desc_t rd_data
);

	kmpd_pkg::desc_t               mem_q [kmpd_pkg::QDEPTH];
	logic [kmpd_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [kmpd_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [kmpd_pkg::QCNT_W-1:0]   count_q;
	logic                          do_wr;
	logic                          do_rd;

	assign q_full  = (count_q == kmpd_pkg::QCNT_W'(kmpd_pkg::QDEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr.push && !q_full;
	assign do_rd   = rd_pop && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == kmpd_pkg::QPTR_W'(kmpd_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == kmpd_pkg::QPTR_W'(kmpd_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/kmpd_back.sv
// Back end: walks the pending event slots of one row sample into the result register,
// one event a cycle while the result is free or popped. Depends on kmpd_pkg.

module kmpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  kmpd_pkg::desc_t   q_data,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output kmpd_pkg::result_t result
);

	kmpd_pkg::desc_t               cur_q;
	logic [kmpd_pkg::SLOTS-1:0]    mask_q;
	kmpd_pkg::result_t             out_q;
	logic                          out_valid_q;

	logic [kmpd_pkg::SLOT_W-1:0]   sel;
	logic [kmpd_pkg::COL_W-1:0]    col;
	logic [kmpd_pkg::SLOTS-1:0]    remaining;
	logic                          advance;
	logic                          fire;
	logic                          need_load;
	kmpd_pkg::event_kind_t         kind;

	// Lowest pending slot goes first.
	always_comb begin
		sel = '0;
		for (int i = kmpd_pkg::SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = kmpd_pkg::SLOT_W'(i);
			end
		end
	end

	assign col       = kmpd_pkg::COL_W'(sel >> 1);
	assign remaining = mask_q & ~(kmpd_pkg::SLOTS'(1) << sel);
	assign advance   = !out_valid_q || pop;
	assign fire      = (|mask_q) && advance;
	assign need_load = !(|mask_q) || (fire && !(|remaining));
	assign q_pop     = need_load && !q_empty;

	always_comb begin
		if (sel[0]) begin
			kind = kmpd_pkg::EV_LONG;
		end else if (cur_q.pressed[col]) begin
			kind = kmpd_pkg::EV_START;
		end else begin
			kind = kmpd_pkg::EV_SHORT;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (fire) begin
			out_q.event_kind <= kind;
			out_q.key_number <= cur_q.key_base + 6'(col);
			out_q.last_event <= !(|remaining);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mask_q <= q_data.slot_mask;
			end else if (fire) begin
				mask_q <= remaining;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

### rtl/core/keypad_matrix_press_detector.sv
// Top level of the keypad matrix press detector.
// Depends on kmpd_pkg, kmpd_front, kmpd_queue and kmpd_back.
//
// Usage:
//   Row samples enter as a queue push: one beat is taken when push is high and
//   full is low. Events leave as a queue pop: while empty is low the oldest event
//   sits on result, and a beat is taken when pop is high.
//   Configuration writes (scan_enable, column_count, row_count, long_press_ticks
//   at indexes 0..3) are taken on any cycle with cfg_valid high; cfg_ready is
//   always high. Write them only while no events are in flight.
// Timing:
//   The first event of a sample passes through the descriptor queue and the serializer's
//   slot mask register into the result register. The event serializer drives one event
//   per cycle while the receiver keeps popping; a sample causes at most 16 events. Samples
//   causing no event are absorbed at one per cycle while full is low. The front end takes a
//   sample every cycle as long as the two-entry descriptor queue has room.
// Reset:
//   All hold counters clear, the block comes up disabled with no rows or columns
//   and a long-press threshold of 50. When the receiver stalls, the result holds,
//   the serializer stops, the queue fills and full rises.

module keypad_matrix_press_detector (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  kmpd_pkg::sample_t    sample,
	output logic                 empty,
	input  logic                 pop,
	output kmpd_pkg::result_t    result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  kmpd_pkg::cfg_index_t cfg_index,
	input  logic [7:0]           cfg_data
);

	kmpd_pkg::qwr_t  q_wr;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;
	kmpd_pkg::desc_t q_data;

	kmpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	kmpd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.q_full  (q_full),
		.rd_pop  (q_pop),
		.q_empty (q_empty),
		.rd_data (q_data)
	);

	kmpd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

### test/keypad_matrix_press_detector_test.sv
// Testbench for keypad_matrix_press_detector: row samples in, key events out.
// Predicts each event from its own copy of the hold counters and registers.
// Depends on kmpd_pkg and the RTL under rtl/core; needs no other file.
`timescale 1ns / 100ps

module keypad_matrix_press_detector_test;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	kmpd_pkg::sample_t    row_sample = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	kmpd_pkg::result_t    event_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	kmpd_pkg::cfg_index_t cfg_index = kmpd_pkg::REG_SCAN_ENABLE;
	logic [7:0]           cfg_data = '0;

	keypad_matrix_press_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (row_sample),
		.empty     (empty),
		.pop       (pop),
		.result    (event_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the block's state and registers
	int                hold_count [kmpd_pkg::MAX_ROWS * kmpd_pkg::MAX_COLUMNS];
	bit                scan_on;
	int                col_limit;
	int                row_limit;
	int                press_limit;
	kmpd_pkg::result_t pending_events [$];

	int push_idle_pct = 31;
	int pop_idle_pct = 31;
	int error_count = 0;
	int samples_sent = 0;
	int samples_scanned = 0;
	int events_checked = 0;
	int reg_writes = 0;
	logic [7:0] held_mask [8];

	function automatic kmpd_pkg::result_t make_event(kmpd_pkg::event_kind_t kind, int key);
		kmpd_pkg::result_t r;
		r.event_kind = kind;
		r.key_number = key[5:0];
		r.last_event = 1'b0;
		return r;
	endfunction

	// Update the counters for one accepted row beat and queue the events it causes.
	function automatic bit predict_events(kmpd_pkg::sample_t s);
		int                thr;
		int                ncol;
		int                idx;
		int                cnt;
		int                key;
		bit                pressed;
		kmpd_pkg::result_t batch [$];
		thr = (press_limit == 0) ? 1 : press_limit;
		if (!scan_on || int'(s.row_index) >= row_limit ||
			int'(s.row_index) >= kmpd_pkg::MAX_ROWS)
			return 1'b0;
		ncol = col_limit;
		if (ncol > kmpd_pkg::MAX_COLUMNS)
			ncol = kmpd_pkg::MAX_COLUMNS;
		if (ncol > 8)
			ncol = 8;
		for (int x = 0; x < ncol; x++) begin
			idx = int'(s.row_index) * kmpd_pkg::MAX_COLUMNS + x;
			cnt = hold_count[idx];
			pressed = s.column_pressed[x];
			key = x + int'(s.row_index) * col_limit;
			if (!pressed) begin
				if (cnt > 0 && cnt < thr)
					batch.push_back(make_event(kmpd_pkg::EV_SHORT, key));
				cnt = 0;
			end else begin
				if (cnt == 0)
					batch.push_back(make_event(kmpd_pkg::EV_START, key));
				if (cnt < thr - 1)
					cnt++;
				if (cnt == thr - 1) begin
					batch.push_back(make_event(kmpd_pkg::EV_LONG, key));
					cnt++;
				end
			end
			hold_count[idx] = cnt;
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last_event = 1'b1;
		foreach (batch[i])
			pending_events.push_back(batch[i]);
		return 1'b1;
	endfunction

	// Compare every popped event with the oldest prediction
	always @(posedge clk) begin
		kmpd_pkg::result_t want;
		if (arst_n === 1'b1 && pop && empty === 1'b0) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event: expected none, actual kind %0d key %0d last %0b",
					$time, event_out.event_kind, event_out.key_number, event_out.last_event);
				error_count++;
			end else begin
				want = pending_events.pop_front();
				events_checked++;
				if (event_out.event_kind !== want.event_kind) begin
					$display("%0t: event_kind mismatch: expected %0d, actual %0d",
						$time, want.event_kind, event_out.event_kind);
					error_count++;
				end
				if (event_out.key_number !== want.key_number) begin
					$display("%0t: key_number mismatch: expected %0d, actual %0d",
						$time, want.key_number, event_out.key_number);
					error_count++;
				end
				if (event_out.last_event !== want.last_event) begin
					$display("%0t: last_event mismatch: expected %0b, actual %0b",
						$time, want.last_event, event_out.last_event);
					error_count++;
				end
			end
		end
	end

	always @(negedge clk)
		pop = ($urandom_range(99) >= pop_idle_pct);

	// Call at a falling edge; returns at the falling edge after the beat, push still high.
	task automatic send_sample(input logic [2:0] row, input logic [7:0] cols, output bit scanned);
		while ($urandom_range(99) < push_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		row_sample.row_index = row;
		row_sample.column_pressed = cols;
		do
			@(posedge clk);
		while (full !== 1'b0);
		scanned = predict_events(row_sample);
		samples_sent++;
		samples_scanned += int'(scanned);
		@(negedge clk);
	endtask

	task automatic send(input logic [2:0] row, input logic [7:0] cols);
		bit scanned;
		send_sample(row, cols, scanned);
	endtask

	// Stop pushing, let every predicted event arrive, then give samples with no event time to clear.
	task automatic drain;
		push = 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input kmpd_pkg::cfg_index_t index, input logic [7:0] value);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (index)
			kmpd_pkg::REG_SCAN_ENABLE:      scan_on = value[0];
			kmpd_pkg::REG_COLUMN_COUNT:     col_limit = int'(value[3:0]);
			kmpd_pkg::REG_ROW_COUNT:        row_limit = int'(value[3:0]);
			kmpd_pkg::REG_LONG_PRESS_TICKS: press_limit = int'(value);
			default: begin
			end
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input bit enable, input int cols, input int rows, input int ticks);
		drain();
		write_reg(kmpd_pkg::REG_SCAN_ENABLE, 8'(enable));
		write_reg(kmpd_pkg::REG_COLUMN_COUNT, 8'(cols));
		write_reg(kmpd_pkg::REG_ROW_COUNT, 8'(rows));
		write_reg(kmpd_pkg::REG_LONG_PRESS_TICKS, 8'(ticks));
	endtask

	// Out of reset the block is disabled with no rows or columns
	task automatic test_reset_state;
		send(3'd0, 8'hff);
		send(3'd7, 8'h5a);
	endtask

	task automatic test_press_lifecycle;
		configure(1'b1, 8, 8, 3);
		send(3'd0, 8'hff);
		send(3'd0, 8'hff);
		send(3'd0, 8'hff);
		send(3'd0, 8'h00);
		send(3'd7, 8'h01);
		send(3'd7, 8'h00);
		send(3'd3, 8'haa);
		send(3'd3, 8'h55);
	endtask

	task automatic test_threshold_edges;
		configure(1'b1, 8, 8, 1);
		send(3'd1, 8'h0f);
		send(3'd1, 8'h00);
		configure(1'b1, 8, 8, 0);
		send(3'd2, 8'hf0);
		send(3'd2, 8'h00);
		configure(1'b1, 8, 8, 255);
		send(3'd4, 8'h81);
		send(3'd4, 8'h81);
		send(3'd4, 8'h00);
	endtask

	task automatic test_bounds;
		// wide counts wrap the key number
		configure(1'b1, 15, 15, 4);
		send(3'd7, 8'hff);
		configure(1'b1, 3, 2, 4);
		send(3'd2, 8'hff);
		send(3'd1, 8'hff);
		// disabled: counters held across the gap
		configure(1'b0, 3, 2, 4);
		send(3'd1, 8'h00);
		configure(1'b1, 3, 2, 4);
		send(3'd1, 8'hff);
		configure(1'b1, 0, 8, 4);
		send(3'd0, 8'hff);
	endtask

	task automatic random_phase(input int quota);
		int  attempts;
		int  scanned_here;
		int  rows_live;
		bit  scanned;
		logic [2:0] row;
		logic [7:0] cols;
		attempts = 0;
		scanned_here = 0;
		rows_live = (row_limit > 8) ? 8 : row_limit;
		while (scanned_here < quota && attempts < quota * 2) begin
			if (rows_live > 0 && $urandom_range(99) < 85)
				row = 3'($urandom_range(rows_live - 1));
			else
				row = 3'($urandom_range(7));
			// mostly hold keys down over many samples, flipping a few at a time
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(1))
					held_mask[row] ^= 8'(1 << $urandom_range(7));
				if ($urandom_range(99) < 10)
					held_mask[row] = '0;
				cols = held_mask[row];
			end else begin
				cols = 8'($urandom_range(255));
			end
			send_sample(row, cols, scanned);
			scanned_here += int'(scanned);
			attempts++;
		end
	endtask

	task automatic test_random_scan;
		int cols;
		int rows;
		int ticks;
		foreach (held_mask[i])
			held_mask[i] = 8'($urandom_range(255));
		// fixed corners first, then random settings
		configure(1'b1, 8, 8, 2);
		random_phase(30);
		configure(1'b1, 15, 15, 255);
		random_phase(20);
		configure(1'b0, 8, 8, 5);
		random_phase(8);
		push_idle_pct = 0;
		pop_idle_pct = 0;
		configure(1'b1, 8, 8, 6);
		random_phase(40);
		push_idle_pct = 31;
		pop_idle_pct = 31;
		for (int p = 0; p < 5; p++) begin
			cols = ($urandom_range(99) < 60) ? 8 : int'($urandom_range(15));
			rows = ($urandom_range(99) < 60) ? int'($urandom_range(8, 1)) :
				int'($urandom_range(15));
			ticks = ($urandom_range(99) < 70) ? int'($urandom_range(8, 2)) :
				int'($urandom_range(255));
			configure($urandom_range(99) < 90, cols, rows, ticks);
			random_phase(28);
		end
	endtask

	initial begin
		foreach (hold_count[i])
			hold_count[i] = 0;
		scan_on = 1'b0;
		col_limit = 0;
		row_limit = 0;
		press_limit = int'(kmpd_pkg::LONG_PRESS_RESET);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_state();
		test_press_lifecycle();
		test_threshold_edges();
		test_bounds();
		test_random_scan();
		drain();
		$display("Sent %0d row samples (%0d scanned) over %0d register writes; checked %0d events.",
			samples_sent, samples_scanned, reg_writes, events_checked);
		if (error_count == 0 && pending_events.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d events outstanding", $time, pending_events.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
